>>> src/assert_macros.svh
// Assertion macros used by the path flattener point engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> src/bpf_pkg.sv
// Types and constants shared by the path flattener modules.
`default_nettype none
package bpf_pkg;
    localparam int COORD_W  = 24;
    localparam int SEG_W    = 7;
    localparam int IDX_W    = 12;
    localparam int REQ_W    = 3;
    localparam int NN_W     = 13;
    localparam int WGT_W    = 19;
    localparam int DEN_W    = 19;
    localparam int B_W      = 20;
    localparam int QUO_W    = 25;
    localparam int ACC_W    = 46;
    localparam int IN_W     = 152;
    localparam int OUT_W    = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int DEF_SEG_QUAD  = 24;
    localparam int DEF_SEG_CUBIC = 32;
    localparam int PATH_CAPACITY_DEF = 4096;
    localparam int MAX_SEGMENTS_DEF  = 64;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR = 3'd0,
        REQ_MOVE  = 3'd1,
        REQ_LINE  = 3'd2,
        REQ_QUAD  = 3'd3,
        REQ_CUBIC = 3'd4
    } t_req;

    typedef struct packed {
        t_req                       kind;
        logic signed [COORD_W-1:0]  ax;
        logic signed [COORD_W-1:0]  ay;
        logic signed [COORD_W-1:0]  bx;
        logic signed [COORD_W-1:0]  by;
        logic signed [COORD_W-1:0]  cx;
        logic signed [COORD_W-1:0]  cy;
        logic [SEG_W-1:0]           segs;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_FETCH, ST_DEN1, ST_DEN2, ST_WGT1, ST_WGT2,
        ST_MAC, ST_PREP, ST_DIV, ST_FIN, ST_EMIT
    } t_bst;
endpackage
`default_nettype wire

>>> src/bpf_front.sv
// Front end: accepts requests, drops unknown kinds and resolves the segment count.
`default_nettype none
module bpf_front #(
    parameter int MAX_SEGMENTS = bpf_pkg::MAX_SEGMENTS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire [bpf_pkg::IN_W-1:0]    s_axis_tdata,
    input  wire [bpf_pkg::REQ_W-1:0]   s_axis_tuser,
    output bpf_pkg::t_cmd              o_cmd,
    output logic                       o_cmd_valid,
    input  wire                        i_cmd_ready
);
    import bpf_pkg::*;

    logic             r_valid;
    t_cmd             r_cmd;
    t_cmd             n_cmd;
    logic             w_known;
    logic [SEG_W-1:0] w_segs;

    always_comb begin
        w_known = 1'b0;
        w_segs  = s_axis_tdata[6*COORD_W +: SEG_W];
        unique case (s_axis_tuser)
            REQ_CLEAR, REQ_MOVE, REQ_LINE: w_known = 1'b1;
            REQ_QUAD: begin
                w_known = 1'b1;
                if (w_segs == '0) w_segs = SEG_W'(DEF_SEG_QUAD);
            end
            REQ_CUBIC: begin
                w_known = 1'b1;
                if (w_segs == '0) w_segs = SEG_W'(DEF_SEG_CUBIC);
            end
            default: w_known = 1'b0;
        endcase
        if (w_segs > SEG_W'(MAX_SEGMENTS)) w_segs = SEG_W'(MAX_SEGMENTS);
        n_cmd.kind = t_req'(s_axis_tuser);
        n_cmd.ax   = s_axis_tdata[0*COORD_W +: COORD_W];
        n_cmd.ay   = s_axis_tdata[1*COORD_W +: COORD_W];
        n_cmd.bx   = s_axis_tdata[2*COORD_W +: COORD_W];
        n_cmd.by   = s_axis_tdata[3*COORD_W +: COORD_W];
        n_cmd.cx   = s_axis_tdata[4*COORD_W +: COORD_W];
        n_cmd.cy   = s_axis_tdata[5*COORD_W +: COORD_W];
        n_cmd.segs = w_segs;
    end

    assign s_axis_tready = !r_valid || i_cmd_ready;
    assign o_cmd         = r_cmd;
    assign o_cmd_valid   = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid && w_known;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_cmd <= n_cmd;
        end
    end
endmodule
`default_nettype wire

>>> src/bpf_fifo.sv
// Short request queue between the front end and the point engine.
`default_nettype none
module bpf_fifo (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  bpf_pkg::t_cmd  i_push,
    input  wire            i_push_valid,
    output logic           o_push_ready,
    output bpf_pkg::t_cmd  o_pop,
    output logic           o_pop_valid,
    input  wire            i_pop_ready
);
    import bpf_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = r_cnt != CNT_W'(QUEUE_DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_pop        = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (w_push) begin
            r_mem[r_wr] <= i_push;
        end
    end
endmodule
`default_nettype wire

>>> src/bpf_back.sv
// Point engine: path state, Bernstein weights, accumulation and rounding division.
`default_nettype none
`include "assert_macros.svh"
module bpf_back #(
    parameter int PATH_CAPACITY = bpf_pkg::PATH_CAPACITY_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  bpf_pkg::t_cmd               i_cmd,
    input  wire                         i_cmd_valid,
    output logic                        o_cmd_ready,
    output logic                        m_axis_tvalid,
    input  wire                         m_axis_tready,
    output logic [bpf_pkg::OUT_W-1:0]   m_axis_tdata,
    output logic                        m_axis_tlast
);
    import bpf_pkg::*;

    localparam int LEN_W = $clog2(PATH_CAPACITY + 1);
    localparam int CNT_W = $clog2(QUO_W);
    localparam int PRD_W = WGT_W + COORD_W + 1;
    localparam int MW    = NN_W + SEG_W;

    t_bst                      r_state;
    t_bst                      n_state;
    t_cmd                      r_cmd;
    logic [LEN_W-1:0]          r_len;
    logic signed [COORD_W-1:0] r_lx;
    logic signed [COORD_W-1:0] r_ly;
    logic signed [COORD_W-1:0] r_p0x;
    logic signed [COORD_W-1:0] r_p0y;
    logic [SEG_W-1:0]          r_n;
    logic [SEG_W-1:0]          r_i;
    logic [NN_W-1:0]           r_nn;
    logic [DEN_W-1:0]          r_den;
    logic [NN_W-1:0]           r_k2;
    logic [NN_W-1:0]           r_ki;
    logic [NN_W-1:0]           r_i2;
    logic [WGT_W-1:0]          r_w [4];
    logic [1:0]                r_term;
    logic signed [ACC_W-1:0]   r_acc_x;
    logic signed [ACC_W-1:0]   r_acc_y;
    logic [B_W-1:0]            r_rem_x;
    logic [B_W-1:0]            r_rem_y;
    logic [QUO_W-1:0]          r_q_x;
    logic [QUO_W-1:0]          r_q_y;
    logic                      r_neg_x;
    logic                      r_neg_y;
    logic [CNT_W-1:0]          r_cnt;
    logic signed [COORD_W-1:0] r_px;
    logic signed [COORD_W-1:0] r_py;
    logic                      r_plast;
    logic                      r_ov;
    logic signed [COORD_W-1:0] r_ox;
    logic signed [COORD_W-1:0] r_oy;
    logic [IDX_W-1:0]          r_oidx;
    logic                      r_olast;

    logic                      w_curve;
    logic                      w_cubic;
    logic                      w_full;
    logic                      w_out_free;
    logic                      w_load;
    logic [SEG_W-1:0]          w_k;
    logic [MW-1:0]             w_k2k;
    logic [MW-1:0]             w_k2i;
    logic [MW-1:0]             w_i2k;
    logic [MW-1:0]             w_i2i;
    logic [MW-1:0]             w_nnn;
    logic [WGT_W-1:0]          w_wsel;
    logic signed [COORD_W-1:0] w_cx;
    logic signed [COORD_W-1:0] w_cy;
    logic signed [PRD_W-1:0]   w_prod_x;
    logic signed [PRD_W-1:0]   w_prod_y;
    logic signed [ACC_W-1:0]   w_a_x;
    logic signed [ACC_W-1:0]   w_a_y;
    logic [ACC_W-1:0]          w_u_x;
    logic [ACC_W-1:0]          w_u_y;
    logic [B_W-1:0]            w_b;
    logic [B_W:0]              w_t_x;
    logic [B_W:0]              w_t_y;
    logic                      w_ge_x;
    logic                      w_ge_y;

    function automatic logic signed [COORD_W-1:0] f_sat(
        input logic [QUO_W-1:0] q,
        input logic             neg
    );
        logic signed [QUO_W:0] v;
        v = neg ? ~{1'b0, q} : {1'b0, q};
        if (v > (QUO_W+1)'((2 ** (COORD_W - 1)) - 1)) begin
            return COORD_W'((2 ** (COORD_W - 1)) - 1);
        end else if (v < -(QUO_W+1)'(2 ** (COORD_W - 1))) begin
            return COORD_W'(2 ** (COORD_W - 1));
        end
        return v[COORD_W-1:0];
    endfunction

    assign w_curve    = (r_cmd.kind == REQ_QUAD) || (r_cmd.kind == REQ_CUBIC);
    assign w_cubic    = r_cmd.kind == REQ_CUBIC;
    assign w_full     = r_len >= LEN_W'(PATH_CAPACITY);
    assign w_out_free = !r_ov || m_axis_tready;
    assign w_load     = (r_state == ST_EMIT) && w_out_free;
    assign w_k        = r_n - r_i;
    assign w_k2k      = r_k2 * w_k;
    assign w_k2i      = r_k2 * r_i;
    assign w_i2k      = r_i2 * w_k;
    assign w_i2i      = r_i2 * r_i;
    assign w_nnn      = r_nn * r_n;
    assign w_wsel     = r_w[r_term];

    always_comb begin
        case (r_term)
            2'd0:    begin w_cx = r_p0x;    w_cy = r_p0y;    end
            2'd1:    begin w_cx = r_cmd.ax; w_cy = r_cmd.ay; end
            2'd2:    begin w_cx = r_cmd.bx; w_cy = r_cmd.by; end
            default: begin w_cx = r_cmd.cx; w_cy = r_cmd.cy; end
        endcase
    end

    assign w_prod_x = $signed({1'b0, w_wsel}) * w_cx;
    assign w_prod_y = $signed({1'b0, w_wsel}) * w_cy;
    assign w_a_x    = $signed({r_acc_x[ACC_W-2:0], 1'b0}) + $signed(ACC_W'(r_den));
    assign w_a_y    = $signed({r_acc_y[ACC_W-2:0], 1'b0}) + $signed(ACC_W'(r_den));
    assign w_u_x    = w_a_x[ACC_W-1] ? ~w_a_x : w_a_x;
    assign w_u_y    = w_a_y[ACC_W-1] ? ~w_a_y : w_a_y;
    assign w_b      = {r_den, 1'b0};
    assign w_t_x    = {r_rem_x, r_q_x[QUO_W-1]};
    assign w_t_y    = {r_rem_y, r_q_y[QUO_W-1]};
    assign w_ge_x   = w_t_x >= {1'b0, w_b};
    assign w_ge_y   = w_t_y >= {1'b0, w_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FETCH;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd_ready = 1'b0;
        unique case (r_state)
            ST_FETCH: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    unique case (i_cmd.kind)
                        REQ_MOVE: n_state = ST_EMIT;
                        REQ_LINE: n_state = w_full ? ST_FETCH : ST_EMIT;
                        REQ_QUAD, REQ_CUBIC: begin
                            n_state = (r_len == '0 || w_full) ? ST_FETCH : ST_DEN1;
                        end
                        default: n_state = ST_FETCH;
                    endcase
                end
            end
            ST_DEN1: n_state = ST_DEN2;
            ST_DEN2: n_state = ST_WGT1;
            ST_WGT1: n_state = ST_WGT2;
            ST_WGT2: n_state = ST_MAC;
            ST_MAC:  n_state = (r_term == 2'd3) ? ST_PREP : ST_MAC;
            ST_PREP: n_state = ST_DIV;
            ST_DIV:  n_state = (r_cnt == CNT_W'(QUO_W - 1)) ? ST_FIN : ST_DIV;
            ST_FIN:  n_state = ST_EMIT;
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = (w_curve && !r_plast) ? ST_WGT1 : ST_FETCH;
                end
            end
            default: n_state = ST_FETCH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_lx  <= '0;
            r_ly  <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
            if (r_state == ST_FETCH && i_cmd_valid &&
                (i_cmd.kind == REQ_CLEAR || i_cmd.kind == REQ_MOVE)) begin
                r_len <= '0;
            end else if (w_load) begin
                r_len <= r_len + 1'b1;
                r_lx  <= r_px;
                r_ly  <= r_py;
            end
        end
        if (w_load) begin
            r_ox    <= r_px;
            r_oy    <= r_py;
            r_oidx  <= IDX_W'(r_len);
            r_olast <= r_plast;
        end
        case (r_state)
            ST_FETCH: begin
                if (i_cmd_valid) begin
                    r_cmd   <= i_cmd;
                    r_px    <= i_cmd.ax;
                    r_py    <= i_cmd.ay;
                    r_p0x   <= r_lx;
                    r_p0y   <= r_ly;
                    r_plast <= 1'b1;
                    r_n     <= i_cmd.segs;
                    r_i     <= SEG_W'(1);
                end
            end
            ST_DEN1: r_nn <= NN_W'(r_n * r_n);
            ST_DEN2: r_den <= w_cubic ? DEN_W'(w_nnn) : DEN_W'(r_nn);
            ST_WGT1: begin
                r_k2 <= NN_W'(w_k * w_k);
                r_ki <= NN_W'(w_k * r_i);
                r_i2 <= NN_W'(r_i * r_i);
            end
            ST_WGT2: begin
                if (w_cubic) begin
                    r_w[0] <= WGT_W'(w_k2k);
                    r_w[1] <= WGT_W'(w_k2i) + WGT_W'({w_k2i, 1'b0});
                    r_w[2] <= WGT_W'(w_i2k) + WGT_W'({w_i2k, 1'b0});
                    r_w[3] <= WGT_W'(w_i2i);
                end else begin
                    r_w[0] <= WGT_W'(r_k2);
                    r_w[1] <= WGT_W'({r_ki, 1'b0});
                    r_w[2] <= WGT_W'(r_i2);
                    r_w[3] <= '0;
                end
                r_term  <= 2'd0;
                r_acc_x <= '0;
                r_acc_y <= '0;
            end
            ST_MAC: begin
                r_acc_x <= r_acc_x + ACC_W'(w_prod_x);
                r_acc_y <= r_acc_y + ACC_W'(w_prod_y);
                r_term  <= r_term + 1'b1;
            end
            ST_PREP: begin
                r_neg_x <= w_a_x[ACC_W-1];
                r_neg_y <= w_a_y[ACC_W-1];
                r_rem_x <= w_u_x[ACC_W-2:QUO_W];
                r_rem_y <= w_u_y[ACC_W-2:QUO_W];
                r_q_x   <= w_u_x[QUO_W-1:0];
                r_q_y   <= w_u_y[QUO_W-1:0];
                r_cnt   <= '0;
            end
            ST_DIV: begin
                r_rem_x <= w_ge_x ? B_W'(w_t_x - {1'b0, w_b}) : w_t_x[B_W-1:0];
                r_rem_y <= w_ge_y ? B_W'(w_t_y - {1'b0, w_b}) : w_t_y[B_W-1:0];
                r_q_x   <= {r_q_x[QUO_W-2:0], w_ge_x};
                r_q_y   <= {r_q_y[QUO_W-2:0], w_ge_y};
                r_cnt   <= r_cnt + 1'b1;
            end
            ST_FIN: begin
                r_px    <= f_sat(r_q_x, r_neg_x);
                r_py    <= f_sat(r_q_y, r_neg_y);
                r_plast <= (r_i == r_n) || (r_len == LEN_W'(PATH_CAPACITY - 1));
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    r_i <= r_i + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {{(OUT_W - 2*COORD_W - IDX_W){1'b0}}, r_oidx, r_oy, r_ox};
    assign m_axis_tlast  = r_olast;

    `ASSERT_PROP(a_len_bound, i_clk, i_rst_n, r_len <= LEN_W'(PATH_CAPACITY))
    `ASSERT_PROP(a_rem_below, i_clk, i_rst_n, (r_state == ST_DIV) |-> (r_rem_x < w_b && r_rem_y < w_b))
    `ASSERT_PROP(a_curve_room, i_clk, i_rst_n, (r_state == ST_MAC) |-> (r_len != '0 && !w_full))
    `ASSERT_NEXT(a_emit_count, i_clk, i_rst_n, w_load, r_len == $past(r_len) + 1'b1)
endmodule
`default_nettype wire

>>> src/bezier_path_flattener.sv
// Top level of the Bezier path flattener: front end, request queue and point engine.
//
//  Channel  Dir  Handshake                      Payload
//  s_axis   in   s_axis_tvalid/s_axis_tready    tdata: coordinates, segments; tuser: kind
//  m_axis   out  m_axis_tvalid/m_axis_tready    tdata: point, index; tlast: final point
//
// Clear is handled in ST_FETCH alone; move-to and line-to also pass through ST_EMIT.
// A curve runs ST_FETCH, ST_DEN1 and ST_DEN2, then per point ST_WGT1, ST_WGT2, ST_MAC,
// ST_PREP, the 25-step restoring divider in ST_DIV, ST_FIN and ST_EMIT.
// Reset is synchronous and active low and empties the queue and output register.
// The front end and engine stall independently; the output register holds a point
// until it is taken.
`default_nettype none
module bezier_path_flattener #(
    parameter int PATH_CAPACITY = bpf_pkg::PATH_CAPACITY_DEF,
    parameter int MAX_SEGMENTS  = bpf_pkg::MAX_SEGMENTS_DEF
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        s_axis_tvalid,
    output logic                       s_axis_tready,
    // a_x, a_y, b_x, b_y, c_x, c_y, segments, zero pad
    input  wire [bpf_pkg::IN_W-1:0]    s_axis_tdata,
    // req_type
    input  wire [bpf_pkg::REQ_W-1:0]   s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire                        m_axis_tready,
    // point_x, point_y, point_index, zero pad
    output logic [bpf_pkg::OUT_W-1:0]  m_axis_tdata,
    output logic                       m_axis_tlast
);
    import bpf_pkg::*;

    t_cmd w_f_cmd;
    logic w_f_valid;
    logic w_f_ready;
    t_cmd w_q_cmd;
    logic w_q_valid;
    logic w_q_ready;

    bpf_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_cmd         (w_f_cmd),
        .o_cmd_valid   (w_f_valid),
        .i_cmd_ready   (w_f_ready)
    );

    bpf_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_f_cmd),
        .i_push_valid (w_f_valid),
        .o_push_ready (w_f_ready),
        .o_pop        (w_q_cmd),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready)
    );

    bpf_back #(.PATH_CAPACITY(PATH_CAPACITY)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_q_cmd),
        .i_cmd_valid   (w_q_valid),
        .o_cmd_ready   (w_q_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );
endmodule
`default_nettype wire

>>> tb/sv/path_point_checker.sv
// Watches both streams of the path flattener, predicts every path point and compares.
`timescale 1ns / 100ps
`default_nettype none
module path_point_checker (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_s_tvalid,
    input  wire                        i_s_tready,
    input  wire [bpf_pkg::IN_W-1:0]    i_s_tdata,
    input  wire [bpf_pkg::REQ_W-1:0]   i_s_tuser,
    input  wire                        i_m_tvalid,
    input  wire                        i_m_tready,
    input  wire [bpf_pkg::OUT_W-1:0]   i_m_tdata,
    input  wire                        i_m_tlast,
    output int                         o_errors,
    output int                         o_pending
);
    import bpf_pkg::*;

    localparam int PATH_CAP = PATH_CAPACITY_DEF;
    localparam int SEG_MAX  = MAX_SEGMENTS_DEF;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [IDX_W-1:0]          idx;
        logic                      last;
    } t_point;

    t_point    point_queue[$];
    int        path_len;
    longint    tail_x;
    longint    tail_y;

    assign o_pending = point_queue.size();

    function automatic longint round_near(longint num, longint den);
        longint a;
        longint b;
        longint q;
        a = 2 * num + den;
        b = 2 * den;
        q = a / b;
        if ((a % b) != 0 && a < 0) q = q - 1;
        return q;
    endfunction

    function automatic longint clamp_coord(longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    task automatic append_point(longint x, longint y);
        t_point p;
        p.x = x[COORD_W-1:0];
        p.y = y[COORD_W-1:0];
        p.idx = path_len[IDX_W-1:0];
        p.last = 1'b0;
        point_queue.push_back(p);
        tail_x = x;
        tail_y = y;
        path_len++;
    endtask

    task automatic flatten_request(logic [REQ_W-1:0] kind, logic [IN_W-1:0] d);
        longint ax, ay, bx, by, cx, cy, n, k, i, x, y;
        longint w0, w1, w2, w3, p0x, p0y;
        int     segs;
        int     emitted;
        ax = longint'($signed(d[23:0]));
        ay = longint'($signed(d[47:24]));
        bx = longint'($signed(d[71:48]));
        by = longint'($signed(d[95:72]));
        cx = longint'($signed(d[119:96]));
        cy = longint'($signed(d[143:120]));
        segs = int'(d[150:144]);
        emitted = 0;
        case (kind)
            REQ_CLEAR: path_len = 0;
            REQ_MOVE, REQ_LINE: begin
                if (kind == REQ_MOVE) path_len = 0;
                if (path_len < PATH_CAP) begin
                    append_point(clamp_coord(ax), clamp_coord(ay));
                    point_queue[$].last = 1'b1;
                end
            end
            REQ_QUAD, REQ_CUBIC: begin
                if (path_len != 0) begin
                    if (segs == 0) segs = (kind == REQ_QUAD) ? DEF_SEG_QUAD : DEF_SEG_CUBIC;
                    if (segs > SEG_MAX) segs = SEG_MAX;
                    n = segs;
                    p0x = tail_x;
                    p0y = tail_y;
                    for (i = 1; i <= n && path_len < PATH_CAP; i++) begin
                        k = n - i;
                        if (kind == REQ_QUAD) begin
                            w0 = k * k;
                            w1 = 2 * k * i;
                            w2 = i * i;
                            x = round_near(w0 * p0x + w1 * ax + w2 * bx, n * n);
                            y = round_near(w0 * p0y + w1 * ay + w2 * by, n * n);
                        end else begin
                            w0 = k * k * k;
                            w1 = 3 * k * k * i;
                            w2 = 3 * k * i * i;
                            w3 = i * i * i;
                            x = round_near(w0 * p0x + w1 * ax + w2 * bx + w3 * cx, n * n * n);
                            y = round_near(w0 * p0y + w1 * ay + w2 * by + w3 * cy, n * n * n);
                        end
                        append_point(clamp_coord(x), clamp_coord(y));
                        emitted++;
                    end
                    if (emitted > 0) point_queue[$].last = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_point e;
        if (!i_rst_n) begin
            path_len = 0;
            tail_x = 0;
            tail_y = 0;
            o_errors <= 0;
            point_queue.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) flatten_request(i_s_tuser, i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                if (point_queue.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10)
                        $display("Unexpected point: x=%h y=%h idx=%0d last=%b",
                                 i_m_tdata[23:0], i_m_tdata[47:24], i_m_tdata[59:48],
                                 i_m_tlast);
                end else begin
                    e = point_queue.pop_front();
                    if (e.x !== i_m_tdata[23:0] || e.y !== i_m_tdata[47:24] ||
                            e.idx !== i_m_tdata[59:48] || e.last !== i_m_tlast ||
                            i_m_tdata[63:60] !== 4'd0) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10)
                            $display("Point mismatch: expected x=%h y=%h idx=%0d last=%b, got x=%h y=%h idx=%0d last=%b pad=%h",
                                     e.x, e.y, e.idx, e.last, i_m_tdata[23:0],
                                     i_m_tdata[47:24], i_m_tdata[59:48], i_m_tlast,
                                     i_m_tdata[63:60]);
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// Stimulus and verdict for the Bezier path flattener testbench.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import bpf_pkg::*;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata;
    logic [REQ_W-1:0]    s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_W-1:0]    m_axis_tdata;
    logic                m_axis_tlast;
    int                  errors;
    int                  pending;
    int                  burst_left;
    int                  stall_mode;
    int                  stall_count;

    bezier_path_flattener DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    path_point_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata), .i_s_tuser(s_axis_tuser),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata), .i_m_tlast(m_axis_tlast),
        .o_errors(errors), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver picks free flow, random, heavy or periodic stalls when stall_count runs out.
    always @(posedge i_clk) begin
        if (stall_count == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_count <= $urandom_range(50, 400);
        end else begin
            stall_count <= stall_count - 1;
        end
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 7) == 0);
            default: m_axis_tready <= (stall_count % 5) < 3;
        endcase
    end

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom);
            default: return 24'($urandom_range(0, 16383)) - 24'd8192;
        endcase
    endfunction

    function automatic logic [6:0] rand_segs();
        case ($urandom_range(0, 9))
            0: return 7'd0;
            1: return 7'($urandom_range(33, 127));
            2: return 7'($urandom_range(9, 32));
            default: return 7'($urandom_range(1, 8));
        endcase
    endfunction

    task automatic send_request(logic [REQ_W-1:0] kind, logic [23:0] ax, logic [23:0] ay,
                                logic [23:0] bx, logic [23:0] by, logic [23:0] cx,
                                logic [23:0] cy, logic [6:0] segs);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {1'b0, segs, cy, cx, by, bx, ay, ax};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
    endtask

    task automatic send_random(logic [REQ_W-1:0] kind);
        send_request(kind, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                     rand_coord(), rand_coord(), rand_segs());
    endtask

    initial begin
        int n;
        int chain;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = REQ_CLEAR;
        m_axis_tready = 1'b0;
        stall_mode = 0;
        stall_count = 0;
        burst_left = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(REQ_QUAD, 24'h000100, 24'h000200, 24'h000300, 24'h000400,
                     24'd0, 24'd0, 7'd4);
        send_request(REQ_MOVE, 24'h7FFFFF, 24'h800000, 24'd0, 24'd0, 24'd0, 24'd0, 7'd0);
        send_request(REQ_LINE, 24'h800000, 24'h7FFFFF, 24'd0, 24'd0, 24'd0, 24'd0, 7'd0);
        send_request(REQ_QUAD, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000,
                     24'd0, 24'd0, 7'd0);
        send_request(REQ_CUBIC, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000,
                     24'hFFFFFF, 24'h000001, 7'd0);
        send_request(REQ_QUAD, 24'h000101, 24'hFFFEFF, 24'h000333, 24'h000000,
                     24'd0, 24'd0, 7'd1);
        send_request(REQ_CUBIC, 24'h001000, 24'hFFF000, 24'h000003, 24'h000005,
                     24'h000007, 24'hFFFFFD, 7'd127);
        send_request(REQ_QUAD, 24'h000001, 24'h000002, 24'h000003, 24'h000001,
                     24'd0, 24'd0, 7'd64);
        send_request(3'd5, 24'h7FFFFF, 24'h7FFFFF, 24'd0, 24'd0, 24'd0, 24'd0, 7'd3);
        send_request(3'd6, 24'h800000, 24'h800000, 24'd0, 24'd0, 24'd0, 24'd0, 7'd3);
        send_request(3'd7, 24'h123456, 24'h654321, 24'd0, 24'd0, 24'd0, 24'd0, 7'd3);
        send_request(REQ_LINE, 24'h000010, 24'h000020, 24'd0, 24'd0, 24'd0, 24'd0, 7'd0);
        send_request(REQ_CLEAR, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 7'd0);
        send_request(REQ_CUBIC, 24'h000100, 24'h000100, 24'h000100, 24'h000100,
                     24'h000100, 24'h000100, 7'd5);
        send_request(REQ_LINE, 24'h000050, 24'hFFFFB0, 24'd0, 24'd0, 24'd0, 24'd0, 7'd0);
        send_request(REQ_CUBIC, 24'h000100, 24'h000200, 24'h000300, 24'h000400,
                     24'h000500, 24'h000600, 7'd2);

        // Fill the path to capacity; the last curve is cut short and later points drop.
        send_request(REQ_MOVE, 24'h000000, 24'h000000, 24'd0, 24'd0, 24'd0, 24'd0, 7'd0);
        for (int i = 0; i < 64; i++) begin
            send_request(REQ_CUBIC, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord(), 7'd64);
        end
        send_request(REQ_LINE, 24'h000001, 24'h000001, 24'd0, 24'd0, 24'd0, 24'd0, 7'd0);
        send_random(REQ_QUAD);
        send_request(REQ_MOVE, 24'h000002, 24'h000003, 24'd0, 24'd0, 24'd0, 24'd0, 7'd0);

        n = 0;
        while (n < 90) begin
            if ($urandom_range(0, 9) < 2) begin
                send_random(REQ_W'($urandom_range(0, 7)));
                n++;
            end else begin
                send_random(REQ_MOVE);
                n++;
                chain = $urandom_range(1, 5);
                for (int j = 0; j < chain; j++) begin
                    send_random(REQ_W'($urandom_range(REQ_LINE, REQ_CUBIC)));
                    n++;
                end
            end
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);

        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
